>>> src/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants of the bit spiral line plotter
// Holds the heading codes, the line length width and the result record that
// the step logic and the top level exchange.
// ----------------------------------------------------------------------------
package bsp_pkg;

    // default width of the signed end point and bounding box coordinates
    localparam int BSP_COORD_BITS = 29;

    // line length width and its saturation value
    localparam int LEN_BITS = 28;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // line headings, clockwise from up
    typedef enum logic [1:0] {
        HEAD_UP    = 2'd0,
        HEAD_RIGHT = 2'd1,
        HEAD_DOWN  = 2'd2,
        HEAD_LEFT  = 2'd3
    } heading_t;

    // one emitted line: heading in the low bits, length above it
    typedef struct packed {
        logic [LEN_BITS-1:0] length;
        heading_t            heading;
    } line_t;

endpackage

>>> src/bit_spiral_line_plotter.sv
// ----------------------------------------------------------------------------
// bit_spiral_line_plotter: turns data bytes into lines of a spiral figure
//
//   channel   dir   payload
//   s_        in    tdata[7:0] data_byte, tuser new_figure
//   m_        out   tdata[1:0] heading, tdata[29:2] line_length, tlast last_line
//
// One line leaves per cycle while m_tready does not stall; a byte gives eight lines,
// nine when it starts a new figure. The figure state register and the single step
// unit between it and the result register produce the lines; the next byte is taken
// in the cycle that produces the eighth line of the current one.
// Reset is synchronous on aresetn and leaves the figure after its first line.
// A stall on m_tready holds the result register and the step sequence.
// ----------------------------------------------------------------------------
module bit_spiral_line_plotter
    import bsp_pkg::*;
#(
    parameter int COORD_BITS = BSP_COORD_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] new_figure
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] heading, [29:2] line_length, [31:30] zero
    output logic        m_tlast
);

    localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

    // sequencing
    logic       busy_reg, busy_next;
    logic       init_pend_reg, init_pend_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] byte_reg, byte_next;

    // figure state
    heading_t              head_reg, head_next;
    logic [COORD_BITS-1:0] end_x_reg, end_x_next;
    logic [COORD_BITS-1:0] end_y_reg, end_y_next;
    logic [COORD_BITS-1:0] min_x_reg, min_x_next;
    logic [COORD_BITS-1:0] max_x_reg, max_x_next;
    logic [COORD_BITS-1:0] min_y_reg, min_y_next;
    logic [COORD_BITS-1:0] max_y_reg, max_y_next;

    // result register
    logic  m_valid_reg, m_valid_next;
    line_t m_line_reg, m_line_next;
    logic  m_last_reg, m_last_next;

    // step unit results
    logic [COORD_BITS-1:0] st_end_x, st_end_y, st_min_x, st_max_x, st_min_y, st_max_y;
    line_t                 st_line;

    logic out_free;
    logic work;
    logic finish;
    logic accept;

    // handshake control
    assign out_free = !m_valid_reg || m_tready;
    assign work     = busy_reg && out_free;
    assign finish   = work && !init_pend_reg && (bit_cnt_reg == 3'd7);
    assign s_tready = !busy_reg || finish;
    assign accept   = s_tvalid && s_tready;

    bsp_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .turn_bit  (byte_reg[3'd7 - bit_cnt_reg]),
        .head_in   (head_reg),
        .end_x     (end_x_reg),
        .end_y     (end_y_reg),
        .min_x     (min_x_reg),
        .max_x     (max_x_reg),
        .min_y     (min_y_reg),
        .max_y     (max_y_reg),
        .end_x_out (st_end_x),
        .end_y_out (st_end_y),
        .min_x_out (st_min_x),
        .max_x_out (st_max_x),
        .min_y_out (st_min_y),
        .max_y_out (st_max_y),
        .line      (st_line)
    );

    // next state of the sequence, figure and result register
    always_comb begin
        busy_next      = busy_reg;
        init_pend_next = init_pend_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_next      = byte_reg;
        head_next      = head_reg;
        end_x_next     = end_x_reg;
        end_y_next     = end_y_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_line_next    = m_line_reg;
        m_last_next    = m_last_reg;

        if (work) begin
            m_valid_next = 1'b1;
            if (init_pend_reg) begin
                // initial up line, figure restarts
                init_pend_next      = 1'b0;
                head_next           = HEAD_UP;
                end_x_next          = '0;
                end_y_next          = COORD_ONE;
                min_x_next          = '0;
                max_x_next          = '0;
                min_y_next          = '0;
                max_y_next          = COORD_ONE;
                m_line_next.heading = HEAD_UP;
                m_line_next.length  = LEN_BITS'(1);
                m_last_next         = 1'b0;
            end else begin
                head_next    = st_line.heading;
                end_x_next   = st_end_x;
                end_y_next   = st_end_y;
                min_x_next   = st_min_x;
                max_x_next   = st_max_x;
                min_y_next   = st_min_y;
                max_y_next   = st_max_y;
                m_line_next  = st_line;
                m_last_next  = (bit_cnt_reg == 3'd7);
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7) begin
                    busy_next = 1'b0;
                end
            end
        end

        // load a new byte
        if (accept) begin
            busy_next      = 1'b1;
            init_pend_next = s_tuser;
            bit_cnt_next   = 3'd0;
            byte_next      = s_tdata;
        end
    end

    // control and figure state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            init_pend_reg <= 1'b0;
            bit_cnt_reg   <= 3'd0;
            m_valid_reg   <= 1'b0;
            head_reg      <= HEAD_UP;
            end_x_reg     <= '0;
            end_y_reg     <= COORD_ONE;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= COORD_ONE;
        end else begin
            busy_reg      <= busy_next;
            init_pend_reg <= init_pend_next;
            bit_cnt_reg   <= bit_cnt_next;
            m_valid_reg   <= m_valid_next;
            head_reg      <= head_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        m_line_reg <= m_line_next;
        m_last_reg <= m_last_next;
    end

    // outputs
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_line_reg};
    assign m_tlast  = m_last_reg;

    // a new byte is only taken when idle or on the eighth line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && busy_reg) |-> (bit_cnt_reg == 3'd7 && !init_pend_reg))
        else $error("byte accepted in the middle of a sequence");

    // a new figure starts with the up line of length one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (work && init_pend_reg) |=>
            (m_tvalid && m_tdata[1:0] == HEAD_UP && m_tdata[29:2] == 28'd1 && !m_tlast))
        else $error("initial line missing");

    // tlast marks exactly the line of bit zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (work && !init_pend_reg) |=> (m_tlast == $past(bit_cnt_reg == 3'd7)))
        else $error("last line flag out of place");

    // lines are never empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:2] != 28'd0))
        else $error("zero line length");

endmodule

>>> src/bsp_step.sv
// ----------------------------------------------------------------------------
// bsp_step: one line step of the spiral
// Turns the heading by one bit, measures the line from the end point to the
// bounding box edge plus one, moves the end point and grows the box.
// ----------------------------------------------------------------------------
module bsp_step
    import bsp_pkg::*;
#(
    parameter int COORD_BITS = BSP_COORD_BITS
) (
    input  logic                  turn_bit,
    input  heading_t              head_in,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [COORD_BITS-1:0] min_x,
    input  logic [COORD_BITS-1:0] max_x,
    input  logic [COORD_BITS-1:0] min_y,
    input  logic [COORD_BITS-1:0] max_y,
    output logic [COORD_BITS-1:0] end_x_out,
    output logic [COORD_BITS-1:0] end_y_out,
    output logic [COORD_BITS-1:0] min_x_out,
    output logic [COORD_BITS-1:0] max_x_out,
    output logic [COORD_BITS-1:0] min_y_out,
    output logic [COORD_BITS-1:0] max_y_out,
    output line_t                 line
);

    localparam int DW = (COORD_BITS > LEN_BITS) ? COORD_BITS : LEN_BITS;
    localparam logic [COORD_BITS-1:0] SIGN_BIT = {1'b1, {(COORD_BITS-1){1'b0}}};

    heading_t              head_new;
    logic [COORD_BITS-1:0] box_edge;
    logic [COORD_BITS-1:0] pos;
    logic [COORD_BITS-1:0] key_a;
    logic [COORD_BITS-1:0] key_b;
    logic [COORD_BITS-1:0] delta;
    logic [DW-1:0]         dist_w;
    logic [DW-1:0]         len_w;
    logic [LEN_BITS-1:0]   len;
    logic [COORD_BITS-1:0] step_c;
    logic [COORD_BITS-1:0] moved;

    // 0 turns clockwise, 1 anti-clockwise
    assign head_new = turn_bit ? heading_t'(head_in + 2'd3) : heading_t'(head_in + 2'd1);

    // pick the box edge and end point coordinate along the new heading
    always_comb begin
        unique case (head_new)
            HEAD_UP: begin
                box_edge = max_y;
                pos      = end_y;
            end
            HEAD_RIGHT: begin
                box_edge = max_x;
                pos      = end_x;
            end
            HEAD_DOWN: begin
                box_edge = min_y;
                pos      = end_y;
            end
            default: begin
                box_edge = min_x;
                pos      = end_x;
            end
        endcase
    end

    // distance in order-preserving unsigned keys, plus one, saturated
    assign key_a  = box_edge ^ SIGN_BIT;
    assign key_b  = pos ^ SIGN_BIT;
    assign delta  = (key_a >= key_b) ? (key_a - key_b) : (key_b - key_a);
    assign dist_w = DW'(delta);
    assign len    = (dist_w >= DW'(LEN_MAX)) ? LEN_MAX : LEN_BITS'(dist_w + DW'(1));

    // move the end point, wrapping at the coordinate width
    assign len_w  = DW'(len);
    assign step_c = len_w[COORD_BITS-1:0];
    assign moved  = (head_new == HEAD_UP || head_new == HEAD_RIGHT) ? (pos + step_c)
                                                                    : (pos - step_c);

    // new end point and grown bounding box
    always_comb begin
        end_x_out = end_x;
        end_y_out = end_y;
        if (head_new == HEAD_UP || head_new == HEAD_DOWN) begin
            end_y_out = moved;
        end else begin
            end_x_out = moved;
        end
        min_x_out = ($signed(end_x_out) < $signed(min_x)) ? end_x_out : min_x;
        max_x_out = ($signed(end_x_out) > $signed(max_x)) ? end_x_out : max_x;
        min_y_out = ($signed(end_y_out) < $signed(min_y)) ? end_y_out : min_y;
        max_y_out = ($signed(end_y_out) > $signed(max_y)) ? end_y_out : max_y;
    end

    assign line.heading = head_new;
    assign line.length  = len;

endmodule

>>> bench/bsp_line_checker.sv
// ----------------------------------------------------------------------------
// bsp_line_checker: result checker of the bit spiral line plotter
// Watches both streams. Every accepted input byte runs through a local
// model of the spiral state, which queues the lines the byte must produce.
// Every accepted result line is compared field by field with the oldest
// queued line. The failure count and the queue depth go up to the bench top.
// ----------------------------------------------------------------------------
module bsp_line_checker
    import bsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] new_figure
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [1:0] heading, [29:2] line_length, [31:30] zero
    input  logic        m_tlast,
    output int unsigned fail_count,
    output int unsigned lines_pending,
    output int unsigned lines_checked,
    output int unsigned longest_line
);

    localparam int CB = BSP_COORD_BITS;

    typedef logic signed [CB-1:0] coord_t;

    // one line the block owes us
    typedef struct {
        heading_t            heading;
        logic [LEN_BITS-1:0] length;
        logic                last;
    } line_exp_t;

    line_exp_t expected_lines[$];

    // local copy of the figure state
    coord_t   pen_x, pen_y;
    coord_t   box_lo_x, box_hi_x, box_lo_y, box_hi_y;
    heading_t pen_heading;

    // figure state right after the initial up line
    task automatic restart_figure();
        pen_x       = '0;
        pen_y       = coord_t'(1);
        box_lo_x    = '0;
        box_hi_x    = '0;
        box_lo_y    = '0;
        box_hi_y    = coord_t'(1);
        pen_heading = HEAD_UP;
    endtask

    // distance to the box edge plus one, saturated
    function automatic logic [LEN_BITS-1:0] reach_len(coord_t box_edge, coord_t pos);
        longint              delta;
        logic [LEN_BITS-1:0] len;
        delta = longint'(box_edge) - longint'(pos);
        if (delta < 0) delta = -delta;
        if (delta >= longint'(LEN_MAX)) len = LEN_MAX;
        else len = LEN_BITS'(delta + 1);
        return len;
    endfunction

    // turn each bit of a byte into one line, msb first
    task automatic plot_byte(logic [7:0] data_byte, logic new_figure);
        line_exp_t           ln;
        logic [1:0]          turned;
        logic [LEN_BITS-1:0] len;
        coord_t              step;
        if (new_figure) begin
            restart_figure();
            ln.heading = HEAD_UP;
            ln.length  = LEN_BITS'(1);
            ln.last    = 1'b0;
            expected_lines.push_back(ln);
        end
        for (int b = 7; b >= 0; b--) begin
            // 1 turns anti-clockwise, 0 clockwise
            turned      = pen_heading + (data_byte[b] ? 2'd3 : 2'd1);
            pen_heading = heading_t'(turned);
            case (pen_heading)
                HEAD_UP:    len = reach_len(box_hi_y, pen_y);
                HEAD_RIGHT: len = reach_len(box_hi_x, pen_x);
                HEAD_DOWN:  len = reach_len(box_lo_y, pen_y);
                default:    len = reach_len(box_lo_x, pen_x);
            endcase
            step = coord_t'(len);
            // move the pen, wrapping at the coordinate width
            case (pen_heading)
                HEAD_UP:    pen_y = pen_y + step;
                HEAD_RIGHT: pen_x = pen_x + step;
                HEAD_DOWN:  pen_y = pen_y - step;
                default:    pen_x = pen_x - step;
            endcase
            // grow the bounding box
            if (pen_x < box_lo_x) box_lo_x = pen_x;
            if (pen_x > box_hi_x) box_hi_x = pen_x;
            if (pen_y < box_lo_y) box_lo_y = pen_y;
            if (pen_y > box_hi_y) box_hi_y = pen_y;
            ln.heading = pen_heading;
            ln.length  = len;
            ln.last    = (b == 0);
            expected_lines.push_back(ln);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at line %0d, %s: got 0x%0h, expected 0x%0h",
                 lines_checked, what, got, want);
        fail_count++;
    endtask

    // watch both channels at the rising edge
    always @(posedge aclk) begin
        line_exp_t want;
        if (!aresetn) begin
            restart_figure();
            expected_lines.delete();
            fail_count    = 0;
            lines_checked = 0;
            longest_line  = 0;
        end else begin
            // input transfer: predict its lines
            if (s_tvalid && s_tready)
                plot_byte(s_tdata, s_tuser);
            // result transfer: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_lines.size() == 0) begin
                    report_mismatch("unexpected line", m_tdata, '0);
                end else begin
                    want = expected_lines.pop_front();
                    if (m_tdata[1:0] !== want.heading)
                        report_mismatch("heading", 32'(m_tdata[1:0]), 32'(want.heading));
                    if (m_tdata[LEN_BITS+1:2] !== want.length)
                        report_mismatch("line_length", 32'(m_tdata[LEN_BITS+1:2]),
                                        32'(want.length));
                    if (m_tdata[31:LEN_BITS+2] !== '0)
                        report_mismatch("tdata padding", 32'(m_tdata[31:LEN_BITS+2]), '0);
                    if (m_tlast !== want.last)
                        report_mismatch("last_line", 32'(m_tlast), 32'(want.last));
                end
                if (32'(m_tdata[LEN_BITS+1:2]) > longest_line)
                    longest_line = 32'(m_tdata[LEN_BITS+1:2]);
                lines_checked++;
            end
        end
        lines_pending = expected_lines.size();
    end

endmodule

>>> bench/tb_bit_spiral_line_plotter.sv
// ----------------------------------------------------------------------------
// tb_bit_spiral_line_plotter: stream testbench of the bit spiral line plotter
// Sends a short directed set of bytes (all turns one way, alternating turns,
// figure restarts) and then about 500 random bytes, mostly continuing long
// figures with an occasional restart. The sender works in bursts, the
// receiver stalls on its own pattern and once holds off long enough to back
// the block up. Checking is done by bsp_line_checker beside the block.
// ----------------------------------------------------------------------------
module tb_bit_spiral_line_plotter;

    localparam int RANDOM_BYTES = 500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    int unsigned fail_count, lines_pending, lines_checked, longest_line;
    int unsigned bytes_sent   = 0;
    int unsigned figures_sent = 0;
    int unsigned burst_left   = 0;
    int unsigned cycle_count  = 0;
    bit          hold_req     = 1'b0;

    // 12 unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    bit_spiral_line_plotter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    bsp_line_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .lines_pending (lines_pending),
        .lines_checked (lines_checked),
        .longest_line  (longest_line)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d lines outstanding",
                     cycle_count, lines_pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: changing stall modes plus one long hold-off
    initial begin
        int unsigned mode_cnt;
        int unsigned rx_mode;
        int unsigned hold_cycles;
        bit          hold_done;
        mode_cnt  = 0;
        rx_mode   = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done   = 1'b1;
                hold_cycles = 0;
                m_tready <= 1'b0;
                while (hold_cycles < LONG_HOLD) begin
                    @(negedge aclk);
                    hold_cycles++;
                end
            end
            mode_cnt++;
            if (mode_cnt >= 150) begin
                mode_cnt = 0;
                rx_mode  = $urandom_range(0, 3);
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((mode_cnt % 5) < 2);
            endcase
        end
    end

    // offer one byte at a falling edge, return at the falling edge after its transfer
    task automatic send_byte(logic [7:0] data_byte, logic new_figure);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 40);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            repeat (gap) @(negedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data_byte;
        s_tuser  <= new_figure;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (new_figure) figures_sent++;
        @(negedge aclk);
    endtask

    initial begin
        logic [7:0] rnd_byte;
        logic       rnd_new;

        // hold reset, then release it at a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: figure left by reset, then restarts with edge patterns
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hF0, 1'b1);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hCC, 1'b1);
        send_byte(8'h33, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);

        // random: long figures, rare restarts, some noise on the restart flag
        for (int i = 0; i < RANDOM_BYTES; i++) begin
            if (i == 100) hold_req = 1'b1;
            rnd_byte = 8'($urandom);
            if ($urandom_range(0, 9) == 0) rnd_new = 1'($urandom);
            else rnd_new = ($urandom_range(0, 31) == 0);
            send_byte(rnd_byte, rnd_new);
        end
        s_tvalid <= 1'b0;

        // drain, then wait on for any stray line
        while (lines_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d bytes over %0d figure starts, checked %0d lines",
                 bytes_sent, figures_sent, lines_checked);
        $display("longest line seen %0d, %0d cycles", longest_line, cycle_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/bsp_pkg.sv
src/bsp_step.sv
src/bit_spiral_line_plotter.sv
bench/bsp_line_checker.sv
bench/tb_bit_spiral_line_plotter.sv
